[hdl/pppfb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pppfb_pkg
// Shared types, constants and checksum helper for the PPP frame builder.
// ----------------------------------------------------------------------------
package pppfb_pkg;

    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE  = 8'h7D;

    localparam logic [7:0]  ADDR_RESET  = 8'hFF;
    localparam logic [7:0]  CTRL_RESET  = 8'h03;
    localparam logic [15:0] PROTO_RESET = 16'h0021;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_ADDRESS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CONTROL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PROTOCOL = 2'd2;

    typedef struct packed {
        logic        hdr;
        logic        esc;
        logic        last;
        logic [7:0]  data;
        logic [15:0] chk;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'b0, s[16]};
    endfunction

endpackage
`default_nettype wire

[hdl/pppfb_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pppfb_front
// Accept payload words, classify them and keep the running checksum.
// ----------------------------------------------------------------------------
module pppfb_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [7:0]        i_payload_byte,
    input  wire logic              i_frame_last,
    input  wire pppfb_pkg::t_q_status i_q_status,
    output logic                   o_stall,
    output logic                   o_push,
    output pppfb_pkg::t_cmd        o_cmd
);
    import pppfb_pkg::*;

    logic        r_inside, n_inside;
    logic [15:0] r_sum, n_sum;
    logic [7:0]  r_held, n_held;
    logic        r_odd, n_odd;
    logic [15:0] w_operand;
    logic [15:0] w_added;
    logic        w_do_add;

    assign o_stall = i_q_status.full;
    assign o_push  = i_valid && !i_q_status.full;

    assign w_operand = r_odd ? {r_held, i_payload_byte} : {i_payload_byte, 8'h00};
    assign w_do_add  = r_odd || i_frame_last;
    assign w_added   = w_do_add ? ones_add(r_sum, w_operand) : r_sum;

    always_comb begin
        o_cmd.hdr  = !r_inside;
        o_cmd.esc  = (i_payload_byte == FLAG_BYTE) || (i_payload_byte == ESC_BYTE);
        o_cmd.last = i_frame_last;
        o_cmd.data = i_payload_byte;
        o_cmd.chk  = ~w_added;
        n_inside   = r_inside;
        n_sum      = r_sum;
        n_held     = r_held;
        n_odd      = r_odd;
        if (o_push) begin
            if (i_frame_last) begin
                n_inside = 1'b0;
                n_sum    = 16'h0000;
                n_held   = 8'h00;
                n_odd    = 1'b0;
            end else begin
                n_inside = 1'b1;
                n_sum    = w_added;
                n_held   = i_payload_byte;
                n_odd    = !r_odd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside <= 1'b0;
            r_sum    <= 16'h0000;
            r_held   <= 8'h00;
            r_odd    <= 1'b0;
        end else begin
            r_inside <= n_inside;
            r_sum    <= n_sum;
            r_held   <= n_held;
            r_odd    <= n_odd;
        end
    end

endmodule
`default_nettype wire

[hdl/pppfb_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pppfb_queue
// Two-entry command queue between the front and the byte sequencer.
// ----------------------------------------------------------------------------
module pppfb_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire pppfb_pkg::t_cmd   i_cmd,
    input  wire logic              i_pop,
    output pppfb_pkg::t_cmd        o_head,
    output pppfb_pkg::t_q_status   o_status
);
    import pppfb_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_status.full  = (r_count == 2'd2);
    assign o_status.empty = (r_count == 2'd0);
    assign o_head         = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("queue count out of range");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_status.empty)
        else $error("pop from empty queue");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_status.full && !i_pop) |-> !i_push)
        else $error("push into full queue");
`endif

endmodule
`default_nettype wire

[hdl/pppfb_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pppfb_back
// Expand queued commands into line words: header, stuffing, checksum, flag.
// ----------------------------------------------------------------------------
module pppfb_back (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire pppfb_pkg::t_cmd        i_head,
    input  wire pppfb_pkg::t_q_status   i_q_status,
    input  wire logic [7:0]             i_address_byte,
    input  wire logic [7:0]             i_control_byte,
    input  wire logic [15:0]            i_protocol_word,
    input  wire logic                   i_stall,
    output logic                        o_pop,
    output logic                        o_valid,
    output logic [7:0]                  o_line_byte,
    output logic                        o_run_last,
    output logic                        o_frame_end
);
    import pppfb_pkg::*;

    typedef enum logic [3:0] {
        S_START,
        S_FLAG,
        S_ADDR,
        S_CTRL,
        S_PROTO_HI,
        S_PROTO_LO,
        S_ESC,
        S_DATA,
        S_CHK_HI,
        S_CHK_LO,
        S_FLAG_END
    } t_step;

    t_step      r_step;
    t_step      w_cur;
    t_step      w_next;
    t_step      w_body;
    logic       w_final;
    logic       w_load;
    logic [7:0] w_byte;

    assign w_body = i_head.esc ? S_ESC : S_DATA;

    always_comb begin
        if (r_step == S_START) begin
            w_cur = i_head.hdr ? S_FLAG : w_body;
        end else begin
            w_cur = r_step;
        end
    end

    always_comb begin
        w_byte  = FLAG_BYTE;
        w_next  = S_START;
        w_final = 1'b0;
        unique case (w_cur)
            S_FLAG: begin
                w_byte = FLAG_BYTE;
                w_next = S_ADDR;
            end
            S_ADDR: begin
                w_byte = i_address_byte;
                w_next = S_CTRL;
            end
            S_CTRL: begin
                w_byte = i_control_byte;
                w_next = S_PROTO_HI;
            end
            S_PROTO_HI: begin
                w_byte = i_protocol_word[15:8];
                w_next = S_PROTO_LO;
            end
            S_PROTO_LO: begin
                w_byte = i_protocol_word[7:0];
                w_next = w_body;
            end
            S_ESC: begin
                w_byte = ESC_BYTE;
                w_next = S_DATA;
            end
            S_DATA: begin
                w_byte  = i_head.data;
                w_next  = i_head.last ? S_CHK_HI : S_START;
                w_final = !i_head.last;
            end
            S_CHK_HI: begin
                w_byte = i_head.chk[15:8];
                w_next = S_CHK_LO;
            end
            S_CHK_LO: begin
                w_byte = i_head.chk[7:0];
                w_next = S_FLAG_END;
            end
            S_FLAG_END: begin
                w_byte  = FLAG_BYTE;
                w_next  = S_START;
                w_final = 1'b1;
            end
            default: begin
                w_byte  = FLAG_BYTE;
                w_next  = S_START;
                w_final = 1'b0;
            end
        endcase
    end

    assign w_load = !i_q_status.empty && (!o_valid || !i_stall);
    assign o_pop  = w_load && w_final;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= S_START;
            o_valid <= 1'b0;
        end else if (w_load) begin
            r_step      <= w_final ? S_START : w_next;
            o_valid     <= 1'b1;
            o_line_byte <= w_byte;
            o_run_last  <= w_final;
            o_frame_end <= (w_cur == S_FLAG_END);
        end else if (!i_stall) begin
            o_valid <= 1'b0;
        end
    end

`ifndef SYNTHESIS
    a_mid_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step != S_START) |-> !i_q_status.empty)
        else $error("sequencer mid-command with empty queue");
    a_end_is_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_frame_end) |-> (o_run_last && o_line_byte == FLAG_BYTE))
        else $error("closing word is not a final flag");
`endif

endmodule
`default_nettype wire

[hdl/ppp_frame_builder_with_checksum.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppp_frame_builder_with_checksum
// PPP-style framer: header, escaped payload, inverted one's-complement sum.
// ----------------------------------------------------------------------------
// Each accepted payload word yields 1 to 10 line words, sent at one word per
// cycle from the output register while the line side does not stall: 1 or 2
// for a plain or escaped byte, plus 5 for the header on the first byte of a
// frame and 3 for checksum and closing flag on the last. The input side takes
// a word every cycle while the two-entry command queue has room, so input and
// output stall independently. Configuration registers are read as each header
// word is loaded, so a write applies to header words loaded after it.
// ----------------------------------------------------------------------------
module ppp_frame_builder_with_checksum (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic [7:0]                     i_payload_byte,
    input  wire logic                           i_frame_last,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic [7:0]                          o_line_byte,
    output logic                                o_run_last,
    output logic                                o_frame_end,
    input  wire logic                           i_cfg_we,
    input  wire logic [pppfb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [15:0]                    i_cfg_data
);
    import pppfb_pkg::*;

    logic [7:0]  r_address_byte;
    logic [7:0]  r_control_byte;
    logic [15:0] r_protocol_word;

    logic      w_push;
    logic      w_pop;
    t_cmd      w_cmd;
    t_cmd      w_head;
    t_q_status w_q_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_address_byte  <= ADDR_RESET;
            r_control_byte  <= CTRL_RESET;
            r_protocol_word <= PROTO_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_ADDRESS:  r_address_byte  <= i_cfg_data[7:0];
                REG_CONTROL:  r_control_byte  <= i_cfg_data[7:0];
                REG_PROTOCOL: r_protocol_word <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    pppfb_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_payload_byte (i_payload_byte),
        .i_frame_last   (i_frame_last),
        .i_q_status     (w_q_status),
        .o_stall        (o_stall),
        .o_push         (w_push),
        .o_cmd          (w_cmd)
    );

    pppfb_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_cmd    (w_cmd),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_q_status)
    );

    pppfb_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (w_head),
        .i_q_status      (w_q_status),
        .i_address_byte  (r_address_byte),
        .i_control_byte  (r_control_byte),
        .i_protocol_word (r_protocol_word),
        .i_stall         (i_stall),
        .o_pop           (w_pop),
        .o_valid         (o_valid),
        .o_line_byte     (o_line_byte),
        .o_run_last      (o_run_last),
        .o_frame_end     (o_frame_end)
    );

endmodule
`default_nettype wire

[dv/ppp_frame_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppp_frame_checker
// Watches the payload, line and register ports of the PPP frame builder,
// computes the framed byte stream that each accepted payload word must
// produce, and matches it in order against the line words that come out.
// ----------------------------------------------------------------------------
module ppp_frame_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    input  wire logic                            i_in_stall,
    input  wire logic [7:0]                      i_payload_byte,
    input  wire logic                            i_frame_last,
    input  wire logic                            i_out_valid,
    input  wire logic                            i_out_stall,
    input  wire logic [7:0]                      i_line_byte,
    input  wire logic                            i_run_last,
    input  wire logic                            i_frame_end,
    input  wire logic                            i_cfg_we,
    input  wire logic [pppfb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [15:0]                     i_cfg_data,
    output int                                   o_fail_count,
    output int                                   o_pending
);
    import pppfb_pkg::*;

    typedef struct packed {
        logic [7:0] line_byte;
        logic       run_last;
        logic       frame_end;
    } t_line_word;

    t_line_word  line_words_due[$];
    int          errors = 0;

    logic [7:0]  address_byte;
    logic [7:0]  control_byte;
    logic [15:0] protocol_word;
    logic        in_frame;
    logic [15:0] payload_sum;
    logic [7:0]  held_byte;
    logic        pair_open;

    function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] total;
        total = {1'b0, a} + {1'b0, b};
        return total[15:0] + {15'b0, total[16]};
    endfunction

    task automatic predict_frame_words(input logic [7:0] b, input logic last);
        t_line_word  words[$];
        logic [15:0] chk;
        if (!in_frame) begin
            words.push_back({FLAG_BYTE, 2'b00});
            words.push_back({address_byte, 2'b00});
            words.push_back({control_byte, 2'b00});
            words.push_back({protocol_word[15:8], 2'b00});
            words.push_back({protocol_word[7:0], 2'b00});
            in_frame = 1'b1;
        end
        if (b == FLAG_BYTE || b == ESC_BYTE) begin
            words.push_back({ESC_BYTE, 2'b00});
        end
        words.push_back({b, 2'b00});
        if (pair_open) begin
            payload_sum = fold_add(payload_sum, {held_byte, b});
            pair_open = 1'b0;
        end else begin
            held_byte = b;
            pair_open = 1'b1;
        end
        if (last) begin
            if (pair_open) begin
                payload_sum = fold_add(payload_sum, {held_byte, 8'h00});
            end
            chk = ~payload_sum;
            words.push_back({chk[15:8], 2'b00});
            words.push_back({chk[7:0], 2'b00});
            words.push_back({FLAG_BYTE, 2'b01});
            in_frame = 1'b0;
            payload_sum = '0;
            held_byte = '0;
            pair_open = 1'b0;
        end
        words[words.size()-1].run_last = 1'b1;
        foreach (words[i]) begin
            line_words_due.push_back(words[i]);
        end
    endtask

    task automatic match_line_word();
        t_line_word want;
        if (line_words_due.size() == 0) begin
            $error("line_byte: expected none, got %h", i_line_byte);
            errors++;
        end else begin
            want = line_words_due.pop_front();
            if (i_line_byte !== want.line_byte) begin
                $error("line_byte: expected %h, got %h", want.line_byte, i_line_byte);
                errors++;
            end
            if (i_run_last !== want.run_last) begin
                $error("run_last: expected %b, got %b", want.run_last, i_run_last);
                errors++;
            end
            if (i_frame_end !== want.frame_end) begin
                $error("frame_end: expected %b, got %b", want.frame_end, i_frame_end);
                errors++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            address_byte = ADDR_RESET;
            control_byte = CTRL_RESET;
            protocol_word = PROTO_RESET;
            in_frame = 1'b0;
            payload_sum = '0;
            held_byte = '0;
            pair_open = 1'b0;
            line_words_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_ADDRESS: begin
                        address_byte = i_cfg_data[7:0];
                    end
                    REG_CONTROL: begin
                        control_byte = i_cfg_data[7:0];
                    end
                    REG_PROTOCOL: begin
                        protocol_word = i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                predict_frame_words(i_payload_byte, i_frame_last);
            end
            if (i_out_valid && !i_out_stall) begin
                match_line_word();
            end
        end
        o_pending <= line_words_due.size();
        o_fail_count <= errors;
    end

endmodule

[dv/tb_ppp_frame_builder_with_checksum.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ppp_frame_builder_with_checksum
// Drives payload words and register writes into the PPP frame builder: a
// directed set of escape, checksum and header cases, then random frames over
// several register settings, with bursty input and random or patterned output stalls.
// ----------------------------------------------------------------------------
module tb_ppp_frame_builder_with_checksum;
    import pppfb_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int                   ITEM_TARGET = 140;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [7:0]           i_payload_byte;
    logic                 i_frame_last;
    logic                 o_valid;
    logic                 i_stall;
    logic [7:0]           o_line_byte;
    logic                 o_run_last;
    logic                 o_frame_end;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [15:0]          i_cfg_data;

    int                   pending_words;
    int                   fail_count;
    int                   burst_left = 0;
    int                   words_sent = 0;

    ppp_frame_builder_with_checksum u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_payload_byte (i_payload_byte),
        .i_frame_last   (i_frame_last),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_line_byte    (o_line_byte),
        .o_run_last     (o_run_last),
        .o_frame_end    (o_frame_end),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    ppp_frame_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_stall     (o_stall),
        .i_payload_byte (i_payload_byte),
        .i_frame_last   (i_frame_last),
        .i_out_valid    (o_valid),
        .i_out_stall    (i_stall),
        .i_line_byte    (o_line_byte),
        .i_run_last     (o_run_last),
        .i_frame_end    (o_frame_end),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending_words)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        int mode;
        int span;
        mode = 0;
        span = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (span == 0) begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(20, 120);
            end else begin
                span--;
            end
            case (mode)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 3) == 0);
                2: i_stall <= ($urandom_range(0, 3) != 0);
                default: i_stall <= (span % 4 == 0);
            endcase
        end
    end

    function automatic logic [7:0] pick_payload_byte();
        case ($urandom_range(0, 9))
            0: return FLAG_BYTE;
            1: return ESC_BYTE;
            2: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [15:0] pick_reg_value();
        case ($urandom_range(0, 3))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic send_word(input logic [7:0] b, input logic last);
        int gap;
        i_valid <= 1'b1;
        i_payload_byte <= b;
        i_frame_last <= last;
        do @(posedge i_clk); while (o_stall);
        words_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 6);
            gap = $urandom_range(1, 7);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_frame(input int len);
        for (int i = 0; i < len; i++) begin
            send_word(pick_payload_byte(), i == len - 1);
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_words != 0);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        int len;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_payload_byte <= '0;
        i_frame_last <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_word(FLAG_BYTE, 1'b0);
        send_word(ESC_BYTE, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b1);
        send_word(FLAG_BYTE, 1'b1);
        send_word(8'h00, 1'b0);
        send_word(8'h00, 1'b1);
        send_word(8'h12, 1'b0);
        send_word(8'h34, 1'b0);
        send_word(8'h56, 1'b1);
        send_word(8'h80, 1'b0);
        send_word(8'h01, 1'b0);
        send_word(8'h80, 1'b0);
        send_word(8'h00, 1'b1);

        wait_drained();
        write_reg(REG_ADDRESS, 16'hAB00);
        write_reg(REG_CONTROL, 16'h00FF);
        write_reg(REG_PROTOCOL, 16'hFFFF);
        write_reg(REG_UNUSED, 16'h1234);
        send_word(8'hAA, 1'b0);
        send_word(8'h55, 1'b1);

        send_word(FLAG_BYTE, 1'b0);
        wait_drained();
        write_reg(REG_ADDRESS, 16'h007E);
        write_reg(REG_PROTOCOL, 16'h7D7E);
        send_word(8'h01, 1'b1);
        send_word(8'h02, 1'b1);

        wait_drained();
        write_reg(REG_CONTROL, 16'h0000);
        write_reg(REG_PROTOCOL, 16'h0000);
        send_word(ESC_BYTE, 1'b1);

        while (words_sent < ITEM_TARGET) begin
            wait_drained();
            if ($urandom_range(0, 1) != 0) write_reg(REG_ADDRESS, pick_reg_value());
            if ($urandom_range(0, 1) != 0) write_reg(REG_CONTROL, pick_reg_value());
            if ($urandom_range(0, 1) != 0) write_reg(REG_PROTOCOL, pick_reg_value());
            if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, pick_reg_value());
            repeat ($urandom_range(2, 6)) begin
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 20)
                                                  : $urandom_range(1, 6);
                send_frame(len);
            end
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending_words == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
